// File: hdl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with positional access.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Fixed field widths of the command and result channels
    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;

    // Command codes (code seven is unused and acts as a no-op)
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ       = 3'd4,
        CMD_WRITE      = 3'd5,
        CMD_CLEAR      = 3'd6
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_INDEX = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Command sequencer states
    typedef enum logic {
        FSM_IDLE   = 1'b0,
        FSM_LOOKUP = 1'b1
    } fsm_t;

endpackage

// File: hdl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Single-port synchronous RAM holding the deque slots; registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 8
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [DATA_WIDTH-1:0] wdata,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
    end

    // Read port, registered; data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/bounded_deque_with_index.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_index
// Bounded double-ended queue in a ring-buffer RAM with indexed read/write.
// ----------------------------------------------------------------------------
// Each command passes the IDLE and LOOKUP states: in the cycle of
// the input transfer the single-port slot RAM is addressed (written for an
// insert or a write, read for a remove or a read) and the front pointer and
// entry count are updated; in LOOKUP, once the result channel is free, the
// registered RAM word is loaded into the output register with status and
// count. The next command is taken once that result has moved into the
// output register, so a stalled result holds at most one command back. The
// slot RAM is not cleared at reset; entries inside the count are always
// written before they are read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_deque_with_index
    import bdq_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [CMD_W-1:0]                 s_command,
    input  logic [DATA_WIDTH-1:0]            s_value_in,
    input  logic [POS_W-1:0]                 s_position,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [DATA_WIDTH-1:0]            m_value_out,
    output logic [STATUS_W-1:0]              m_status,
    output logic [$clog2(DEPTH+1)-1:0]       m_item_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int OFF_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SUM_W = OFF_W + 1;

    // State
    fsm_t                  state_reg, state_next;
    logic [PTR_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    status_t               status_pend_reg, status_pend_next;
    logic                  rd_pend_reg, rd_pend_next;

    logic                  m_valid_reg, m_valid_next;
    logic [DATA_WIDTH-1:0] m_value_out_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [CNT_W-1:0]      m_item_count_reg;

    // RAM interface
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [PTR_W-1:0]      ram_addr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // Datapath helpers
    cmd_t                  cmd;
    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic                  is_full;
    logic                  is_empty;
    logic                  pos_bad;
    logic [OFF_W-1:0]      offset;
    logic [SUM_W-1:0]      slot_sum;
    logic [SUM_W-1:0]      slot_wrap;
    logic [PTR_W-1:0]      slot_addr;
    logic [PTR_W-1:0]      front_dec;
    logic [PTR_W-1:0]      front_inc;

    assign cmd      = cmd_t'(s_command);
    assign s_ready  = (state_reg == FSM_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == FSM_LOOKUP) && out_free;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign pos_bad  = (OFF_W'(s_position) >= OFF_W'(count_reg));

    // Offset from the front for the slot this command touches
    always_comb begin
        unique case (cmd)
            CMD_PUSH_BACK:         offset = OFF_W'(count_reg);
            CMD_POP_BACK:          offset = OFF_W'(count_reg - CNT_W'(1));
            CMD_READ, CMD_WRITE:   offset = OFF_W'(s_position);
            default:               offset = '0;
        endcase
    end

    // Ring wrap: front + offset stays below twice the depth when in range
    assign slot_sum  = SUM_W'(front_reg) + SUM_W'(offset);
    assign slot_wrap = (slot_sum >= SUM_W'(DEPTH)) ? slot_sum - SUM_W'(DEPTH) : slot_sum;
    assign slot_addr = slot_wrap[PTR_W-1:0];

    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - PTR_W'(1);
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + PTR_W'(1);

    // Sequencer: next state, pointer updates and RAM control
    always_comb begin
        state_next       = state_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        status_pend_next = status_pend_reg;
        rd_pend_next     = rd_pend_reg;
        ram_wr_en        = 1'b0;
        ram_rd_en        = 1'b0;
        ram_addr         = slot_addr;

        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    state_next       = FSM_LOOKUP;
                    status_pend_next = ST_OK;
                    rd_pend_next     = 1'b0;
                    unique case (cmd)
                        CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                status_pend_next = ST_FULL;
                            end else begin
                                ram_wr_en  = 1'b1;
                                ram_addr   = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (is_full) begin
                                status_pend_next = ST_FULL;
                            end else begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (is_empty) begin
                                status_pend_next = ST_EMPTY;
                            end else begin
                                ram_rd_en    = 1'b1;
                                rd_pend_next = 1'b1;
                                front_next   = front_inc;
                                count_next   = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (is_empty) begin
                                status_pend_next = ST_EMPTY;
                            end else begin
                                ram_rd_en    = 1'b1;
                                rd_pend_next = 1'b1;
                                count_next   = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_READ: begin
                            if (pos_bad) begin
                                status_pend_next = ST_INDEX;
                            end else begin
                                ram_rd_en    = 1'b1;
                                rd_pend_next = 1'b1;
                            end
                        end
                        CMD_WRITE: begin
                            if (pos_bad) begin
                                status_pend_next = ST_INDEX;
                            end else begin
                                ram_wr_en = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            front_next = '0;
                            count_next = '0;
                        end
                        default: begin
                            // unused code: no change
                        end
                    endcase
                end
            end
            FSM_LOOKUP: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Pending result info, no reset needed
    always_ff @(posedge aclk) begin
        status_pend_reg <= status_pend_next;
        rd_pend_reg     <= rd_pend_next;
    end

    // Output register: loaded when a command finishes lookup
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_out_reg  <= rd_pend_reg ? ram_rdata : '0;
            m_status_reg     <= status_pend_reg;
            m_item_count_reg <= count_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value_out  = m_value_out_reg;
    assign m_status     = m_status_reg;
    assign m_item_count = m_item_count_reg;

    // Slot store
    bdq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (PTR_W)
    ) u_ram (
        .aclk  (aclk),
        .wr_en (ram_wr_en),
        .rd_en (ram_rd_en),
        .addr  (ram_addr),
        .wdata (s_value_in),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Entry count never exceeds the ring size
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // Front pointer stays inside the ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        front_reg <= PTR_W'(DEPTH - 1))
        else $error("front pointer out of range");

    // Every input transfer is followed by a lookup cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == FSM_LOOKUP))
        else $error("accepted command skipped lookup");

    // A full error is only reported with a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> (m_item_count == CNT_W'(DEPTH)))
        else $error("full error with room left");

    // An empty error is only reported with an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> (m_item_count == '0))
        else $error("empty error with entries held");

    // RAM is never written and read in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("RAM write and read collide");

endmodule
